>>> hdl/tpbb_pkg.sv
// ----------------------------------------------------------------------------
// tpbb_pkg: shared types and constants for the transformed point bounding box
// Default widths, register indexes and the pipeline enable bundle.
// ----------------------------------------------------------------------------
package tpbb_pkg;

    // Default coordinate width (signed, half of the bits are fraction).
    localparam int unsigned COORD_WIDTH = 32;
    // Default coefficient width (signed, half of the bits are fraction).
    localparam int unsigned COEF_WIDTH  = 16;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_WIDTH = 3;
    typedef logic [CFG_ADDR_WIDTH-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_ROW_X  = 3'd0;
    localparam cfg_addr_t REG_ROW_Y  = 3'd1;
    localparam cfg_addr_t REG_ROW_Z  = 3'd2;
    localparam cfg_addr_t REG_OFFS_X = 3'd3;
    localparam cfg_addr_t REG_OFFS_Y = 3'd4;
    localparam cfg_addr_t REG_OFFS_Z = 3'd5;

    // Load enables for the two arithmetic stages of each axis.
    typedef struct packed {
        logic prod;   // load the product registers from the input register
        logic sum;    // load the transformed coordinate register
    } pipe_en_t;

endpackage : tpbb_pkg

>>> hdl/transformed_point_bounding_box.sv
// ----------------------------------------------------------------------------
// transformed_point_bounding_box: bounds of affine-transformed 3D points
// Each slave beat carries one point; it is multiplied by a 3x3 coefficient
// matrix, offset, floored to the point format and saturated. Running minimum
// and maximum are kept per axis. A beat with s_tlast high closes the set: one
// master beat then carries the six bounds, including that point, and the
// trackers start afresh. Beats without s_tlast give no master beat.
// Throughput is one point per cycle but for a held closing point (see below);
// a closing point passes the input register, the product registers, the
// transformed coordinate register and the result register in that order.
// When the receiver stalls, points that do not close a set still flow
// into the trackers; only a closing point waits for the result register to
// empty, and s_tready falls behind it. After reset the matrix is the
// identity, the offsets are zero and the trackers hold the most positive and
// most negative values. The user writes configuration through cfg_wr_en /
// cfg_addr / cfg_wdata only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module transformed_point_bounding_box #(
    parameter int unsigned COORD_WIDTH = tpbb_pkg::COORD_WIDTH,
    parameter int unsigned COEF_WIDTH  = tpbb_pkg::COEF_WIDTH,
    parameter int unsigned IN_WIDTH    = ((3 * COORD_WIDTH + 7) / 8) * 8,
    parameter int unsigned OUT_WIDTH   = ((6 * COORD_WIDTH + 7) / 8) * 8,
    parameter int unsigned CFG_WIDTH   = (3 * COEF_WIDTH > COORD_WIDTH) ?
                                         3 * COEF_WIDTH : COORD_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // point_x, point_y, point_z from bit 0 up, zero padded to bytes
    input  logic [IN_WIDTH-1:0]           s_tdata,
    input  logic                          s_tlast,   // last_point
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z from bit 0 up
    output logic [OUT_WIDTH-1:0]          m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wr_en,
    input  tpbb_pkg::cfg_addr_t           cfg_addr,
    input  logic [CFG_WIDTH-1:0]          cfg_wdata
);

    localparam int unsigned FRAC = COEF_WIDTH / 2;
    localparam int unsigned RW   = 3 * COEF_WIDTH;
    localparam logic [RW-1:0] ONE = RW'(1) << FRAC;

    // Configuration registers.
    logic [RW-1:0]                 row_reg  [3];
    logic signed [COORD_WIDTH-1:0] offs_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0]  <= ONE;
            row_reg[1]  <= ONE << COEF_WIDTH;
            row_reg[2]  <= ONE << (2 * COEF_WIDTH);
            offs_reg[0] <= '0;
            offs_reg[1] <= '0;
            offs_reg[2] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tpbb_pkg::REG_ROW_X:  row_reg[0]  <= cfg_wdata[RW-1:0];
                tpbb_pkg::REG_ROW_Y:  row_reg[1]  <= cfg_wdata[RW-1:0];
                tpbb_pkg::REG_ROW_Z:  row_reg[2]  <= cfg_wdata[RW-1:0];
                tpbb_pkg::REG_OFFS_X: offs_reg[0] <= cfg_wdata[COORD_WIDTH-1:0];
                tpbb_pkg::REG_OFFS_Y: offs_reg[1] <= cfg_wdata[COORD_WIDTH-1:0];
                tpbb_pkg::REG_OFFS_Z: offs_reg[2] <= cfg_wdata[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Elastic pipeline control. Stage 0 is the input register, stage 1 the
    // products, stage 2 the transformed point. A stage loads when it is empty
    // or its content moves on; the trackers take every stage 2 beat except a
    // closing one that finds the result register still full.
    logic v0_reg, v1_reg, v2_reg;
    logic last0_reg, last1_reg, last2_reg;
    logic adv0, adv1, adv2, take, slot_free;
    tpbb_pkg::pipe_en_t pipe_en;

    assign take     = v2_reg && (!last2_reg || slot_free);
    assign adv2     = !v2_reg || take;
    assign adv1     = !v1_reg || adv2;
    assign adv0     = !v0_reg || adv1;
    assign s_tready = adv0;

    assign pipe_en.prod = adv1;
    assign pipe_en.sum  = adv2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv0) begin
                v0_reg <= s_tvalid;
            end
            if (adv1) begin
                v1_reg <= v0_reg;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Input register payload.
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg, pz_reg;

    always_ff @(posedge aclk) begin
        if (adv0) begin
            px_reg    <= s_tdata[COORD_WIDTH-1:0];
            py_reg    <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
            pz_reg    <= s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
            last0_reg <= s_tlast;
        end
        if (adv1) begin
            last1_reg <= last0_reg;
        end
        if (adv2) begin
            last2_reg <= last1_reg;
        end
    end

    // One multiply-accumulate unit per output axis.
    logic signed [COORD_WIDTH-1:0] t [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        tpbb_axis #(
            .COORD_WIDTH (COORD_WIDTH),
            .COEF_WIDTH  (COEF_WIDTH)
        ) u_axis (
            .aclk      (aclk),
            .pipe_en   (pipe_en),
            .point_x   (px_reg),
            .point_y   (py_reg),
            .point_z   (pz_reg),
            .row_coefs (row_reg[a]),
            .offset    (offs_reg[a]),
            .coord     (t[a])
        );
    end

    tpbb_track #(
        .COORD_WIDTH (COORD_WIDTH),
        .OUT_WIDTH   (OUT_WIDTH)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .take_last (last2_reg),
        .tx        (t[0]),
        .ty        (t[1]),
        .tz        (t[2]),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule : transformed_point_bounding_box

>>> hdl/tpbb_axis.sv
// ----------------------------------------------------------------------------
// tpbb_axis: one output axis of the affine transform
// Three products in one registered stage, then sum, floor, offset and
// saturation in the next.
// ----------------------------------------------------------------------------
module tpbb_axis #(
    parameter int unsigned COORD_WIDTH = tpbb_pkg::COORD_WIDTH,
    parameter int unsigned COEF_WIDTH  = tpbb_pkg::COEF_WIDTH
) (
    input  logic                          aclk,
    input  tpbb_pkg::pipe_en_t            pipe_en,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic [3*COEF_WIDTH-1:0]       row_coefs,
    input  logic signed [COORD_WIDTH-1:0] offset,
    output logic signed [COORD_WIDTH-1:0] coord
);

    localparam int unsigned FRAC = COEF_WIDTH / 2;
    localparam int unsigned PW   = COORD_WIDTH + COEF_WIDTH;   // product width
    localparam int unsigned SW   = PW + 2;                     // sum of three
    localparam int unsigned HW   = SW - FRAC;                  // after floor
    localparam int unsigned TW   = HW + 1;                     // with offset

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [PW-1:0]          prod_reg  [3];
    logic signed [PW-1:0]          prod_next [3];
    logic signed [COORD_WIDTH-1:0] coord_reg;
    logic signed [COORD_WIDTH-1:0] coord_next;

    logic signed [PW-1:0] pt_ext   [3];
    logic signed [PW-1:0] coef_ext [3];
    logic signed [SW-1:0] sum;
    logic signed [HW-1:0] floored;
    logic signed [TW-1:0] total;

    always_comb begin
        pt_ext[0] = PW'(point_x);
        pt_ext[1] = PW'(point_y);
        pt_ext[2] = PW'(point_z);
        for (int i = 0; i < 3; i++) begin
            coef_ext[i]  = PW'($signed(row_coefs[i*COEF_WIDTH +: COEF_WIDTH]));
            prod_next[i] = pt_ext[i] * coef_ext[i];
        end
    end

    // The arithmetic shift of the exact sum is the floor of the quotient.
    always_comb begin
        sum     = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
        floored = HW'(sum >>> FRAC);
        total   = TW'(floored) + TW'(offset);
        if ((&total[TW-1:COORD_WIDTH-1]) || !(|total[TW-1:COORD_WIDTH-1])) begin
            coord_next = total[COORD_WIDTH-1:0];
        end else if (total[TW-1]) begin
            coord_next = C_MIN;
        end else begin
            coord_next = C_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.prod) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (pipe_en.sum) begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule : tpbb_axis

>>> hdl/tpbb_track.sv
// ----------------------------------------------------------------------------
// tpbb_track: running per-axis bounds and the result register
// Updates the minimum and maximum per beat and presents the box on a last beat.
// ----------------------------------------------------------------------------
module tpbb_track #(
    parameter int unsigned COORD_WIDTH = tpbb_pkg::COORD_WIDTH,
    parameter int unsigned OUT_WIDTH   = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          take,      // a transformed beat leaves
    input  logic                          take_last,
    input  logic signed [COORD_WIDTH-1:0] tx,
    input  logic signed [COORD_WIDTH-1:0] ty,
    input  logic signed [COORD_WIDTH-1:0] tz,
    output logic                          slot_free, // result register can load
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_WIDTH-1:0]          m_tdata
);

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] low_reg  [3];
    logic signed [COORD_WIDTH-1:0] high_reg [3];
    logic signed [COORD_WIDTH-1:0] low_next [3];
    logic signed [COORD_WIDTH-1:0] high_next[3];
    logic signed [COORD_WIDTH-1:0] t        [3];
    logic                          valid_reg;
    logic [6*COORD_WIDTH-1:0]      data_reg;
    logic [6*COORD_WIDTH-1:0]      data_next;

    always_comb begin
        t[0] = tx;
        t[1] = ty;
        t[2] = tz;
        for (int i = 0; i < 3; i++) begin
            low_next[i]  = (t[i] < low_reg[i])  ? t[i] : low_reg[i];
            high_next[i] = (t[i] > high_reg[i]) ? t[i] : high_reg[i];
        end
        data_next = {high_next[2], high_next[1], high_next[0],
                     low_next[2],  low_next[1],  low_next[0]};
    end

    assign slot_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                low_reg[i]  <= C_MAX;
                high_reg[i] <= C_MIN;
            end
        end else begin
            if (take && take_last) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
            if (take) begin
                for (int i = 0; i < 3; i++) begin
                    low_reg[i]  <= take_last ? C_MAX : low_next[i];
                    high_reg[i] <= take_last ? C_MIN : high_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && take_last) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_WIDTH'(data_reg);

endmodule : tpbb_track
